// File: hw/rtl/led_matrix_pwm_row_scanner_macros.svh
// Assertion macros for the LED matrix row scanner.
`ifndef LED_MATRIX_PWM_ROW_SCANNER_MACROS_SVH
`define LED_MATRIX_PWM_ROW_SCANNER_MACROS_SVH

`ifndef SYNTH
`define LMPRS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lmprs: same-cycle check failed");
`define LMPRS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lmprs: next-cycle check failed");
`else
`define LMPRS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define LMPRS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// File: hw/rtl/lmprs_pkg.sv
package lmprs_pkg;

    localparam int COLUMNS       = 32;
    localparam int ROWS_PER_HALF = 8;
    localparam int HALF_SIZE     = ROWS_PER_HALF * COLUMNS;
    localparam int FB_SIZE       = 2 * HALF_SIZE;

    localparam int HALF_AW   = $clog2(HALF_SIZE);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS_PER_HALF);
    localparam int PIX_W     = 8;
    localparam int ADDR_W    = 9;
    localparam int ROW_SEL_W = 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [PIX_W-1:0] PHASE_STEP      = 8'd128;
    localparam logic [PIX_W-1:0] GRAY_STEP_RESET = 8'd4;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic               we;
        logic [HALF_AW-1:0] waddr;
        logic [PIX_W-1:0]   wdata;
        logic               re;
        logic [HALF_AW-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [ROW_SEL_W-1:0] row_sel;
        logic                 last;
        logic                 lower;
        logic                 upper;
    } out_item_t;

    function automatic logic [ROW_SEL_W-1:0] row_to_sel(input logic [ROW_W-1:0] row);
        logic [ROW_W+ROW_SEL_W-1:0] wide;
        wide = {{ROW_SEL_W{1'b0}}, row};
        return wide[ROW_SEL_W-1:0];
    endfunction

endpackage

// File: hw/rtl/led_matrix_pwm_row_scanner.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: mode; tdata: address, value
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: upper, lower, row; tlast: last
// cfg       in   cfg_wr_en                      cfg_wr_data: gray_step
//
// Scan tick: 32 column results, one per cycle when the sink keeps up; the
// single read port of each frame buffer half sets the pace.
// After reset both halves are zeroed, one address a cycle, with
// s_axis_tready low. A stalled sink holds the scan; two results buffer.
`include "led_matrix_pwm_row_scanner_macros.svh"

module led_matrix_pwm_row_scanner
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lmprs_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // pixel_address, pixel_value
    input  logic                                s_axis_tuser,  // mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lmprs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // upper_bit, lower_bit, row_select
    output logic                                m_axis_tlast,
    input  logic                                cfg_wr_en,
    input  logic [lmprs_pkg::PIX_W-1:0]         cfg_wr_data
);

    logic [lmprs_pkg::PIX_W-1:0]      gray_reg;
    logic [lmprs_pkg::ADDR_W-1:0]     in_addr;
    logic [lmprs_pkg::PIX_W-1:0]      in_value;
    lmprs_pkg::ram_req_t              up_req;
    lmprs_pkg::ram_req_t              lo_req;
    logic [lmprs_pkg::PIX_W-1:0]      up_rdata;
    logic [lmprs_pkg::PIX_W-1:0]      lo_rdata;
    logic                             push_valid;
    lmprs_pkg::out_item_t             push_item;
    lmprs_pkg::out_item_t             out_item;
    logic [lmprs_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic                             fifo_pop;

    assign in_addr  = s_axis_tdata[lmprs_pkg::ADDR_W-1:0];
    assign in_value = s_axis_tdata[lmprs_pkg::ADDR_W +: lmprs_pkg::PIX_W];
    assign fifo_pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg <= lmprs_pkg::GRAY_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            gray_reg <= cfg_wr_data;
        end
    end

    lmprs_ram u_ram_upper
    (
        .clk   (clk),
        .req   (up_req),
        .rdata (up_rdata)
    );

    lmprs_ram u_ram_lower
    (
        .clk   (clk),
        .req   (lo_req),
        .rdata (lo_rdata)
    );

    lmprs_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_mode    (s_axis_tuser),
        .in_addr    (in_addr),
        .in_value   (in_value),
        .gray_step  (gray_reg),
        .fifo_count (fifo_count),
        .fifo_pop   (fifo_pop),
        .up_rdata   (up_rdata),
        .lo_rdata   (lo_rdata),
        .up_req     (up_req),
        .lo_req     (lo_req),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    lmprs_ofifo u_ofifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (fifo_pop),
        .out_valid (m_axis_tvalid),
        .out_item  (out_item),
        .count     (fifo_count)
    );

    assign m_axis_tdata = lmprs_pkg::OUT_DATA_W'({out_item.row_sel, out_item.lower,
                                                  out_item.upper});
    assign m_axis_tlast = out_item.last;

    `LMPRS_ASSERT_IMP(a_fifo_no_overflow, clk, rst_n, push_valid && (fifo_count == lmprs_pkg::FIFO_CNT_W'(lmprs_pkg::FIFO_DEPTH)), fifo_pop)
    `LMPRS_ASSERT_NEXT(a_busy_after_tick, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)
    `LMPRS_ASSERT_IMP(a_no_scan_read_when_ready, clk, rst_n, s_axis_tready, !up_req.re && !lo_req.re)

endmodule

// File: hw/rtl/lmprs_ram.sv
module lmprs_ram
(
    input  logic                            clk,
    input  lmprs_pkg::ram_req_t             req,
    output logic [lmprs_pkg::PIX_W-1:0]     rdata
);

    logic [lmprs_pkg::PIX_W-1:0] mem [lmprs_pkg::HALF_SIZE];
    logic [lmprs_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lmprs_seq.sv
module lmprs_seq
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_mode,
    input  logic [lmprs_pkg::ADDR_W-1:0]        in_addr,
    input  logic [lmprs_pkg::PIX_W-1:0]         in_value,
    input  logic [lmprs_pkg::PIX_W-1:0]         gray_step,
    input  logic [lmprs_pkg::FIFO_CNT_W-1:0]    fifo_count,
    input  logic                                fifo_pop,
    input  logic [lmprs_pkg::PIX_W-1:0]         up_rdata,
    input  logic [lmprs_pkg::PIX_W-1:0]         lo_rdata,
    output lmprs_pkg::ram_req_t                 up_req,
    output lmprs_pkg::ram_req_t                 lo_req,
    output logic                                push_valid,
    output lmprs_pkg::out_item_t                push_item
);

    localparam int OCC_W = lmprs_pkg::FIFO_CNT_W + 1;

    lmprs_pkg::state_t state_reg, state_next;

    logic [lmprs_pkg::COL_W-1:0]     col_reg, col_next;
    logic [lmprs_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [lmprs_pkg::PIX_W-1:0]     cmp_reg, cmp_next;
    logic [lmprs_pkg::HALF_AW-1:0]   clr_reg, clr_next;
    logic                            pend_reg, pend_next;
    logic [lmprs_pkg::PIX_W-1:0]     cmp_pipe_reg;
    logic [lmprs_pkg::ROW_SEL_W-1:0] row_pipe_reg;
    logic                            last_pipe_reg;

    logic                            issue;
    logic                            col_last;
    logic                            row_last;
    logic                            clr_last;
    logic [OCC_W-1:0]                occ;
    logic [lmprs_pkg::PIX_W-1:0]     row_inc;
    logic [lmprs_pkg::HALF_AW-1:0]   scan_addr;
    logic                            wr_upper;
    logic                            wr_lower;

    assign col_last = (col_reg == lmprs_pkg::COL_W'(lmprs_pkg::COLUMNS - 1));
    assign row_last = (row_reg == lmprs_pkg::ROW_W'(lmprs_pkg::ROWS_PER_HALF - 1));
    assign clr_last = (clr_reg == lmprs_pkg::HALF_AW'(lmprs_pkg::HALF_SIZE - 1));
    assign occ      = OCC_W'(fifo_count) + OCC_W'(pend_reg);
    assign issue    = (state_reg == lmprs_pkg::ST_SCAN) &&
                      (occ < (OCC_W'(lmprs_pkg::FIFO_DEPTH) + OCC_W'(fifo_pop)));

    assign scan_addr = lmprs_pkg::HALF_AW'(row_reg) * lmprs_pkg::HALF_AW'(lmprs_pkg::COLUMNS)
                     + lmprs_pkg::HALF_AW'(col_reg);

    assign wr_upper = (32'(in_addr) < lmprs_pkg::HALF_SIZE);
    assign wr_lower = (32'(in_addr) >= lmprs_pkg::HALF_SIZE) &&
                      (32'(in_addr) < lmprs_pkg::FB_SIZE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmprs_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = lmprs_pkg::ST_IDLE;
                end
            end
            lmprs_pkg::ST_IDLE:
            begin
                if (in_valid && (in_mode == lmprs_pkg::MODE_TICK))
                begin
                    state_next = lmprs_pkg::ST_SCAN;
                end
            end
            lmprs_pkg::ST_SCAN:
            begin
                if (issue && col_last)
                begin
                    state_next = lmprs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmprs_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        up_req   = '0;
        lo_req   = '0;
        case (state_reg)
            lmprs_pkg::ST_CLEAR:
            begin
                up_req.we    = 1'b1;
                up_req.waddr = clr_reg;
                lo_req.we    = 1'b1;
                lo_req.waddr = clr_reg;
            end
            lmprs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_mode == lmprs_pkg::MODE_WRITE))
                begin
                    up_req.we    = wr_upper;
                    up_req.waddr = lmprs_pkg::HALF_AW'(in_addr);
                    up_req.wdata = in_value;
                    lo_req.we    = wr_lower;
                    lo_req.waddr = lmprs_pkg::HALF_AW'(32'(in_addr) - lmprs_pkg::HALF_SIZE);
                    lo_req.wdata = in_value;
                end
            end
            lmprs_pkg::ST_SCAN:
            begin
                up_req.re    = issue;
                up_req.raddr = scan_addr;
                lo_req.re    = issue;
                lo_req.raddr = scan_addr;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // counters and PWM compare level
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cmp_next  = cmp_reg;
        clr_next  = clr_reg;
        pend_next = issue;
        row_inc   = lmprs_pkg::PHASE_STEP +
                    (row_last ? (lmprs_pkg::PHASE_STEP + gray_step) : '0);
        if (state_reg == lmprs_pkg::ST_CLEAR)
        begin
            clr_next = clr_reg + 1'b1;
        end
        if (issue)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
                cmp_next = cmp_reg + lmprs_pkg::PHASE_STEP + row_inc;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                cmp_next = cmp_reg + lmprs_pkg::PHASE_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmprs_pkg::ST_CLEAR;
            col_reg   <= '0;
            row_reg   <= '0;
            cmp_reg   <= '0;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cmp_reg   <= cmp_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_pipe_reg  <= cmp_reg;
            row_pipe_reg  <= lmprs_pkg::row_to_sel(row_reg);
            last_pipe_reg <= col_last;
        end
    end

    assign push_valid        = pend_reg;
    assign push_item.upper   = (up_rdata > cmp_pipe_reg);
    assign push_item.lower   = (lo_rdata > cmp_pipe_reg);
    assign push_item.last    = last_pipe_reg;
    assign push_item.row_sel = row_pipe_reg;

endmodule

// File: hw/rtl/lmprs_ofifo.sv
module lmprs_ofifo
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  lmprs_pkg::out_item_t                push_item,
    input  logic                                pop,
    output logic                                out_valid,
    output lmprs_pkg::out_item_t                out_item,
    output logic [lmprs_pkg::FIFO_CNT_W-1:0]    count
);

    lmprs_pkg::out_item_t mem_reg [lmprs_pkg::FIFO_DEPTH];

    logic [lmprs_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lmprs_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lmprs_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    localparam logic [lmprs_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        lmprs_pkg::FIFO_PTR_W'(lmprs_pkg::FIFO_DEPTH - 1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;

endmodule
